### src/nru_page_table_mmu_defines.svh
// ----------------------------------------------------------------------------
// nru_page_table_mmu_defines
// Assertion macros shared by the NRU page table modules.
// ----------------------------------------------------------------------------
`ifndef NRU_PAGE_TABLE_MMU_DEFINES_SVH
`define NRU_PAGE_TABLE_MMU_DEFINES_SVH

// same-cycle implication, checked out of reset
`define NPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define NPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/npt_pkg.sv
// ----------------------------------------------------------------------------
// npt_pkg
// Shared constants and control types of the NRU page table MMU.
// ----------------------------------------------------------------------------
package npt_pkg;

  localparam int NUM_PAGES  = 256;
  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int MAX_FRAMES = 16;
  localparam int FRAME_W    = 4;
  localparam int FCNT_W     = 5;
  localparam int ADDR_W     = 16;
  localparam int VPN_W      = 8;
  localparam int FAULT_W    = 32;
  localparam int LFSR_W     = 8;
  localparam int KEY_W      = 2 + PAGE_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [FCNT_W-1:0] DEFAULT_FRAMES = FCNT_W'(10);
  localparam logic [LFSR_W-1:0] LFSR_MASK      = 8'hB8;
  localparam logic [LFSR_W-1:0] LFSR_RESET     = 8'h01;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LFSR_SEED   = 1'b1;

  localparam logic ACC_WRITE = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_step;
    logic commit;
  } npt_cmd_t;

  typedef struct packed {
    logic hit;
    logic free;
    logic scan_last;
  } npt_sts_t;

endpackage

### src/npt_ctrl.sv
// ----------------------------------------------------------------------------
// npt_ctrl
// Access sequencer: lookup, victim scan, commit and result strobe.
// ----------------------------------------------------------------------------
`include "nru_page_table_mmu_defines.svh"

module npt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  input  npt_pkg::npt_sts_t sts,
  output npt_pkg::npt_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    cmd            = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts.hit || sts.free) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.scan_clear = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `NPT_ASSERT_NOW(a_strobe_idle, out_valid_r, state_r == S_IDLE, "strobe while busy")
  `NPT_ASSERT_NEXT(a_accept_look, start && !busy, state_r == S_LOOK, "accept lost")
  `NPT_ASSERT_NEXT(a_commit_strobe, cmd.commit, out_valid_r, "commit without strobe")

endmodule

### src/npt_datapath.sv
// ----------------------------------------------------------------------------
// npt_datapath
// Frame table, NRU victim scan, LFSR, fault counter and result registers.
// ----------------------------------------------------------------------------
`include "nru_page_table_mmu_defines.svh"

module npt_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  npt_pkg::npt_cmd_t                  cmd,
  output npt_pkg::npt_sts_t                  sts,
  input  logic                               in_cmd,
  input  logic [npt_pkg::ADDR_W-1:0]         in_address,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [npt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [npt_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [npt_pkg::VPN_W-1:0]          out_page,
  output logic [npt_pkg::FRAME_W-1:0]        out_frame,
  output logic                               out_fault,
  output logic                               out_evicted,
  output logic [npt_pkg::VPN_W-1:0]          out_victim_page,
  output logic [npt_pkg::FAULT_W-1:0]        out_fault_total
);

  localparam int MF = npt_pkg::MAX_FRAMES;

  // request
  logic                        wr_r;
  logic [npt_pkg::PAGE_W-1:0]  page_r;
  logic [npt_pkg::VPN_W-1:0]   vpn;

  // frame table
  logic [npt_pkg::PAGE_W-1:0]  page_of_r [MF];
  logic [MF-1:0]               ref_r;
  logic [MF-1:0]               mod_r;
  logic [MF-1:0]               valid;
  logic [MF-1:0]               match;
  logic [MF-1:0]               lmatch;

  // global state
  logic [npt_pkg::FCNT_W-1:0]  frames_used_r;
  logic [npt_pkg::FCNT_W-1:0]  frame_count_r;
  logic [npt_pkg::FCNT_W-1:0]  limit;
  logic [npt_pkg::LFSR_W-1:0]  lfsr_r;
  logic [npt_pkg::LFSR_W-1:0]  lfsr_step;
  logic [npt_pkg::LFSR_W-1:0]  seed;
  logic [npt_pkg::PAGE_W-1:0]  last_page_r;
  logic                        last_valid_r;
  logic [npt_pkg::FAULT_W-1:0] fault_cnt_r;
  logic [npt_pkg::FAULT_W-1:0] fault_cnt_nxt;

  // victim scan
  logic [npt_pkg::FRAME_W-1:0] scan_idx_r;
  logic                        best_found_r;
  logic [npt_pkg::KEY_W-1:0]   best_key_r;
  logic [npt_pkg::FRAME_W-1:0] best_frame_r;
  logic [npt_pkg::PAGE_W-1:0]  best_page_r;
  logic                        cur_valid;
  logic                        cur_ref;
  logic                        cur_mod;
  logic [npt_pkg::PAGE_W-1:0]  cur_page;
  logic [npt_pkg::KEY_W-1:0]   cur_key;

  // access decision
  logic                        hit;
  logic                        free;
  logic [npt_pkg::FRAME_W-1:0] hit_frame;
  logic                        hit_mod;
  logic [npt_pkg::FRAME_W-1:0] target;
  logic                        evict;
  logic                        fault;
  logic                        clear_last;

  assign vpn = in_address[npt_pkg::ADDR_W-1 -: npt_pkg::VPN_W];

  always_comb begin
    hit_frame = '0;
    hit_mod   = 1'b0;
    cur_valid = 1'b0;
    cur_ref   = 1'b0;
    cur_mod   = 1'b0;
    cur_page  = '0;
    for (int i = 0; i < MF; i++) begin
      valid[i]  = (npt_pkg::FCNT_W'(i) < frames_used_r);
      match[i]  = valid[i] && (page_of_r[i] == page_r);
      lmatch[i] = valid[i] && (page_of_r[i] == last_page_r);
      if (match[i]) begin
        hit_frame = hit_frame | npt_pkg::FRAME_W'(i);
        hit_mod   = hit_mod | mod_r[i];
      end
      if (scan_idx_r == npt_pkg::FRAME_W'(i)) begin
        cur_valid = valid[i];
        cur_ref   = ref_r[i];
        cur_mod   = mod_r[i];
        cur_page  = page_of_r[i];
      end
    end
  end

  assign hit = |match;

  always_comb begin
    if (frame_count_r == '0) begin
      limit = npt_pkg::FCNT_W'(1);
    end else if (frame_count_r > npt_pkg::FCNT_W'(MF)) begin
      limit = npt_pkg::FCNT_W'(MF);
    end else begin
      limit = frame_count_r;
    end
  end

  assign free    = (frames_used_r < limit);
  assign cur_key = {cur_ref, cur_mod, cur_page - lfsr_r[npt_pkg::PAGE_W-1:0]};

  assign sts.hit       = hit;
  assign sts.free      = free;
  assign sts.scan_last = (scan_idx_r == npt_pkg::FRAME_W'(MF - 1));

  assign evict  = !hit && !free;
  assign fault  = !hit || ((wr_r == npt_pkg::ACC_WRITE) && !hit_mod);
  assign target = hit  ? hit_frame :
                  free ? frames_used_r[npt_pkg::FRAME_W-1:0] : best_frame_r;
  assign clear_last = last_valid_r && (last_page_r != page_r);

  assign fault_cnt_nxt = (fault && (fault_cnt_r != '1)) ? fault_cnt_r + 1'b1 : fault_cnt_r;

  assign lfsr_step = lfsr_r[0] ? ((lfsr_r >> 1) ^ npt_pkg::LFSR_MASK) : (lfsr_r >> 1);
  assign seed      = (cfg_data == '0) ? npt_pkg::LFSR_RESET : cfg_data;
  assign cfg_ready = 1'b1;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_used_r <= '0;
      frame_count_r <= npt_pkg::DEFAULT_FRAMES;
      lfsr_r        <= npt_pkg::LFSR_RESET;
      last_page_r   <= '0;
      last_valid_r  <= 1'b0;
      fault_cnt_r   <= '0;
      scan_idx_r    <= '0;
      best_found_r  <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index == npt_pkg::CFG_FRAME_COUNT)) begin
        frame_count_r <= cfg_data[npt_pkg::FCNT_W-1:0];
      end
      if (cfg_valid && (cfg_index == npt_pkg::CFG_LFSR_SEED)) begin
        lfsr_r <= seed;
      end else if (cmd.commit && evict) begin
        lfsr_r <= lfsr_step;
      end
      if (cmd.scan_clear) begin
        scan_idx_r   <= '0;
        best_found_r <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_idx_r <= scan_idx_r + 1'b1;
        if (cur_valid && (!best_found_r || (cur_key < best_key_r))) begin
          best_found_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        if (!hit && free) begin
          frames_used_r <= frames_used_r + 1'b1;
        end
        fault_cnt_r  <= fault_cnt_nxt;
        last_page_r  <= page_r;
        last_valid_r <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wr_r   <= in_cmd;
      page_r <= vpn[npt_pkg::PAGE_W-1:0];
    end
    if (cmd.scan_step && cur_valid && (!best_found_r || (cur_key < best_key_r))) begin
      best_key_r   <= cur_key;
      best_frame_r <= scan_idx_r;
      best_page_r  <= cur_page;
    end
    for (int i = 0; i < MF; i++) begin
      if (cmd.commit && (target == npt_pkg::FRAME_W'(i))) begin
        page_of_r[i] <= page_r;
        ref_r[i]     <= 1'b1;
        mod_r[i]     <= (hit && hit_mod) || (wr_r == npt_pkg::ACC_WRITE);
      end else if (cmd.commit && clear_last && lmatch[i]) begin
        ref_r[i] <= 1'b0;
      end
    end
    if (cmd.commit) begin
      out_page        <= npt_pkg::VPN_W'(page_r);
      out_frame       <= target;
      out_fault       <= fault;
      out_evicted     <= evict;
      out_victim_page <= evict ? npt_pkg::VPN_W'(best_page_r) : '0;
      out_fault_total <= fault_cnt_nxt;
    end
  end

  `NPT_ASSERT_NOW(a_used_bound, 1'b1, frames_used_r <= npt_pkg::FCNT_W'(MF), "frames overrun")
  `NPT_ASSERT_NOW(a_victim_found, cmd.commit && evict, best_found_r, "no victim at commit")
  `NPT_ASSERT_NOW(a_lfsr_live, 1'b1, lfsr_r != '0, "scan LFSR stuck at zero")

endmodule

### src/nru_page_table_mmu.sv
// ----------------------------------------------------------------------------
// nru_page_table_mmu
// Page table MMU with not-recently-used replacement over up to 16 frames.
// ----------------------------------------------------------------------------
// Usage:
//   Access channel: drive in_cmd (0 read, 1 write) and in_address with start
//   high; the access is taken at a clock edge where start is high and busy
//   is low. busy stays high until the access has finished.
//   Result channel: out_valid pulses for one cycle with the page, frame,
//   fault, eviction and running fault total. The receiver cannot stall.
//   Config channel: cfg_valid with cfg_index/cfg_data, cfg_ready always high.
//   Index 0 sets the frame limit, index 1 loads the victim-scan LFSR.
//   Write config only while busy is low and no result is pending.
// Sequence:
//   For a hit or a free-frame fill the access passes the lookup and commit
//   states before out_valid rises; an eviction adds a scan of the frame
//   table between them, one frame per cycle. A new access can be taken in
//   the out_valid cycle.
// Reset:
//   rst_n low empties the frame table, clears the fault count and loads
//   the LFSR with 1; the frame limit returns to 10.
// ----------------------------------------------------------------------------
module nru_page_table_mmu (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_cmd,
  input  logic [npt_pkg::ADDR_W-1:0]     in_address,
  output logic                           out_valid,
  output logic [npt_pkg::VPN_W-1:0]      out_page,
  output logic [npt_pkg::FRAME_W-1:0]    out_frame,
  output logic                           out_fault,
  output logic                           out_evicted,
  output logic [npt_pkg::VPN_W-1:0]      out_victim_page,
  output logic [npt_pkg::FAULT_W-1:0]    out_fault_total,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [npt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [npt_pkg::CFG_DATA_W-1:0] cfg_data
);

  npt_pkg::npt_cmd_t cmd;
  npt_pkg::npt_sts_t sts;

  npt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  npt_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_cmd          (in_cmd),
    .in_address      (in_address),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_page        (out_page),
    .out_frame       (out_frame),
    .out_fault       (out_fault),
    .out_evicted     (out_evicted),
    .out_victim_page (out_victim_page),
    .out_fault_total (out_fault_total)
  );

endmodule

### test/nru_page_table_mmu_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nru_page_table_mmu_test
// Self-checking bench for the NRU page table MMU. A directed pass walks
// hits, first writes, free-frame fills, evictions and the register
// extremes. Random phases follow, each with new register settings and a
// page working set sized around the frame limit. A built-in page table
// predictor supplies the expected result for every accepted access.
// ----------------------------------------------------------------------------
module nru_page_table_mmu_test;

  localparam int   PERIOD        = 10;
  localparam int   SETTLE_CYCLES = 24;
  localparam int   STALL_LIMIT   = 2000;
  localparam int   GAP_LONG_MAX  = 60;
  localparam int   RANDOM_PHASES = 12;
  localparam int   PHASE_ITEMS   = 140;
  localparam int   REPORT_MAX    = 10;
  localparam logic ACC_READ      = 1'b0;
  localparam logic [npt_pkg::FCNT_W-1:0] FRAMES_AT_RESET = npt_pkg::FCNT_W'(10);
  localparam logic [npt_pkg::LFSR_W-1:0] SCAN_TAPS       = 8'hB8;

  typedef struct packed {
    logic [npt_pkg::VPN_W-1:0]   page;
    logic [npt_pkg::FRAME_W-1:0] frame;
    logic                        fault;
    logic                        evicted;
    logic [npt_pkg::VPN_W-1:0]   victim_page;
    logic [npt_pkg::FAULT_W-1:0] fault_total;
  } translation_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           start      = 1'b0;
  logic                           in_cmd     = 1'b0;
  logic [npt_pkg::ADDR_W-1:0]     in_address = '0;
  logic                           cfg_valid  = 1'b0;
  logic [npt_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [npt_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
  logic                           busy;
  logic                           out_valid;
  logic [npt_pkg::VPN_W-1:0]      out_page;
  logic [npt_pkg::FRAME_W-1:0]    out_frame;
  logic                           out_fault;
  logic                           out_evicted;
  logic [npt_pkg::VPN_W-1:0]      out_victim_page;
  logic [npt_pkg::FAULT_W-1:0]    out_fault_total;
  logic                           cfg_ready;

  // predicted page table
  logic                        page_present [npt_pkg::NUM_PAGES];
  logic                        page_ref     [npt_pkg::NUM_PAGES];
  logic                        page_mod     [npt_pkg::NUM_PAGES];
  logic [npt_pkg::FRAME_W-1:0] page_frame   [npt_pkg::NUM_PAGES];
  int unsigned                 frames_handed;
  logic [npt_pkg::VPN_W-1:0]   prev_page;
  logic                        prev_valid;
  logic [npt_pkg::FAULT_W-1:0] faults;
  logic [npt_pkg::LFSR_W-1:0]  scan_start;
  logic [npt_pkg::FCNT_W-1:0]  frame_limit_reg;

  translation_t expected_translations [$];

  int          mismatches          = 0;
  int          accesses_sent       = 0;
  int          results_seen        = 0;
  int          evictions_predicted = 0;
  int          config_writes       = 0;
  int          steady_left         = 0;
  int          stall_cycles        = 0;

  nru_page_table_mmu DUT (.*);

  always #(PERIOD / 2) clk = ~clk;

  function automatic int unsigned clamp_limit(input logic [npt_pkg::FCNT_W-1:0] fc);
    if (fc == 0) return 1;
    if (fc > npt_pkg::MAX_FRAMES) return npt_pkg::MAX_FRAMES;
    return fc;
  endfunction

  function automatic void predict_translation(input logic wr,
                                              input logic [npt_pkg::ADDR_W-1:0] addr);
    translation_t              t;
    logic [npt_pkg::VPN_W-1:0] pg;
    logic [npt_pkg::VPN_W-1:0] cand;
    int                        victim;
    pg = npt_pkg::VPN_W'(int'(addr[npt_pkg::ADDR_W-1 -: npt_pkg::VPN_W]) % npt_pkg::NUM_PAGES);
    t = '0;
    t.page = pg;
    if (page_present[pg]) begin
      page_ref[pg] = 1'b1;
      if (wr == npt_pkg::ACC_WRITE && !page_mod[pg]) begin
        page_mod[pg] = 1'b1;
        t.fault = 1'b1;
      end
    end else begin
      if (frames_handed < clamp_limit(frame_limit_reg)) begin
        page_frame[pg] = npt_pkg::FRAME_W'(frames_handed);
        frames_handed++;
      end else begin
        victim = -1;
        for (int cls = 0; cls < 4 && victim < 0; cls++) begin
          for (int k = 0; k < npt_pkg::NUM_PAGES && victim < 0; k++) begin
            cand = npt_pkg::VPN_W'((int'(scan_start) + k) % npt_pkg::NUM_PAGES);
            if (page_present[cand] && page_ref[cand] == cls[1] && page_mod[cand] == cls[0])
              victim = int'(cand);
          end
        end
        if (victim >= 0) begin
          t.evicted = 1'b1;
          t.victim_page = npt_pkg::VPN_W'(victim);
          page_frame[pg] = page_frame[victim];
          page_frame[victim] = '0;
          page_present[victim] = 1'b0;
          page_ref[victim] = 1'b0;
          page_mod[victim] = 1'b0;
          scan_start = (scan_start >> 1) ^ (scan_start[0] ? SCAN_TAPS : '0);
        end else begin
          page_frame[pg] = '0;
        end
      end
      page_present[pg] = 1'b1;
      page_ref[pg] = 1'b1;
      page_mod[pg] = (wr == npt_pkg::ACC_WRITE);
      t.fault = 1'b1;
    end
    if (t.fault && faults != '1) faults++;
    if (prev_valid && prev_page != pg) page_ref[prev_page] = 1'b0;
    prev_page = pg;
    prev_valid = 1'b1;
    t.frame = page_frame[pg];
    t.fault_total = faults;
    expected_translations.insert(expected_translations.size(), t);
    evictions_predicted += t.evicted;
  endfunction

  // mostly short gaps, a few long ones, and runs with none
  function automatic int pick_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      steady_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, GAP_LONG_MAX);
  endfunction

  task automatic issue_access(input logic wr, input logic [npt_pkg::ADDR_W-1:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_cmd <= wr;
    in_address <= addr;
    do @(posedge clk); while (busy);
    predict_translation(wr, addr);
    accesses_sent++;
  endtask

  task automatic settle_block();
    start <= 1'b0;
    while (expected_translations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // hold keeps valid up for a transfer that follows directly
  task automatic write_register(input logic [npt_pkg::CFG_IDX_W-1:0] idx,
                                input logic [npt_pkg::CFG_DATA_W-1:0] data, input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (!hold) cfg_valid <= 1'b0;
    if (idx == npt_pkg::CFG_FRAME_COUNT) begin
      frame_limit_reg = data[npt_pkg::FCNT_W-1:0];
    end else if (idx == npt_pkg::CFG_LFSR_SEED) begin
      scan_start = (data[npt_pkg::LFSR_W-1:0] == 0) ? npt_pkg::LFSR_W'(1) :
                                                      data[npt_pkg::LFSR_W-1:0];
    end
    config_writes++;
  endtask

  task automatic test_first_accesses();
    issue_access(ACC_READ, 16'h0000);
    issue_access(ACC_READ, 16'h00FF);
    issue_access(npt_pkg::ACC_WRITE, 16'h0012);
    issue_access(npt_pkg::ACC_WRITE, 16'h0034);
    issue_access(npt_pkg::ACC_WRITE, 16'hFFFF);
    issue_access(ACC_READ, 16'hFF00);
    for (int p = 1; p <= 8; p++) issue_access(ACC_READ, {npt_pkg::VPN_W'(p), 8'(p * 16)});
    issue_access(ACC_READ, 16'h5A5A);
    issue_access(npt_pkg::ACC_WRITE, 16'hA5A5);
  endtask

  task automatic test_frame_limit();
    settle_block();
    write_register(npt_pkg::CFG_FRAME_COUNT, 8'hFF, 1'b0);
    issue_access(ACC_READ, 16'h1000);
    issue_access(npt_pkg::ACC_WRITE, 16'h1180);
    issue_access(ACC_READ, 16'h12C3);
    settle_block();
    write_register(npt_pkg::CFG_FRAME_COUNT, 8'hE0, 1'b0);
    issue_access(ACC_READ, 16'h7700);
    settle_block();
    write_register(npt_pkg::CFG_FRAME_COUNT, 8'h10, 1'b0);
    issue_access(npt_pkg::ACC_WRITE, 16'h8800);
  endtask

  task automatic test_scan_seed();
    settle_block();
    write_register(npt_pkg::CFG_FRAME_COUNT, 8'h01, 1'b1);
    write_register(npt_pkg::CFG_LFSR_SEED, 8'h00, 1'b0);
    issue_access(ACC_READ, 16'h9900);
    issue_access(npt_pkg::ACC_WRITE, 16'hAA55);
    settle_block();
    write_register(npt_pkg::CFG_LFSR_SEED, 8'hFF, 1'b0);
    issue_access(ACC_READ, 16'hBB00);
    issue_access(npt_pkg::ACC_WRITE, 16'hCC01);
  endtask

  task automatic test_random_traffic();
    logic [npt_pkg::FCNT_W-1:0]     fc;
    logic [npt_pkg::CFG_DATA_W-1:0] fc_data;
    logic [npt_pkg::CFG_DATA_W-1:0] seed_data;
    logic [npt_pkg::VPN_W-1:0]      pg;
    logic [npt_pkg::VPN_W-1:0]      last_pg;
    logic                           wr;
    int unsigned                    ws;
    int unsigned                    base;
    int unsigned                    wr_pct;
    int                             r;
    last_pg = '0;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle_block();
      case (ph % 6)
        0: fc = npt_pkg::FCNT_W'(1);
        1: fc = npt_pkg::FCNT_W'(16);
        2: fc = npt_pkg::FCNT_W'(0);
        3: fc = npt_pkg::FCNT_W'(31);
        4: fc = npt_pkg::FCNT_W'(17);
        default: fc = npt_pkg::FCNT_W'($urandom_range(2, 15));
      endcase
      fc_data = {3'($urandom), fc};
      case (ph % 4)
        0: seed_data = 8'h00;
        1: seed_data = 8'hFF;
        2: seed_data = 8'h01;
        default: seed_data = 8'($urandom);
      endcase
      if ($urandom_range(1) == 1) begin
        write_register(npt_pkg::CFG_FRAME_COUNT, fc_data, 1'b1);
        write_register(npt_pkg::CFG_LFSR_SEED, seed_data, 1'b0);
      end else begin
        write_register(npt_pkg::CFG_LFSR_SEED, seed_data, 1'b1);
        write_register(npt_pkg::CFG_FRAME_COUNT, fc_data, 1'b0);
      end
      ws = $urandom_range(1, clamp_limit(fc) + 8);
      base = $urandom_range(0, npt_pkg::NUM_PAGES - 1);
      wr_pct = $urandom_range(5, 70);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 10) pg = last_pg;
        else if (r < 92) pg = npt_pkg::VPN_W'(base + $urandom_range(0, ws - 1));
        else pg = npt_pkg::VPN_W'($urandom);
        wr = ($urandom_range(99) < wr_pct) ? npt_pkg::ACC_WRITE : ACC_READ;
        issue_access(wr, {pg, 8'($urandom)});
        last_pg = pg;
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    translation_t want;
    translation_t got;
    if (rst_n && out_valid) begin
      got = {out_page, out_frame, out_fault, out_evicted, out_victim_page, out_fault_total};
      results_seen++;
      if (expected_translations.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with none expected: page %02h frame %0d", $realtime,
                   got.page, got.frame);
      end else begin
        want = expected_translations.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display({"%0t: expected page %02h frame %0d fault %0b evicted %0b",
                      " victim %02h total %0d"},
                     $realtime, want.page, want.frame, want.fault, want.evicted,
                     want.victim_page, want.fault_total);
            $display({"%0t:   actual page %02h frame %0d fault %0b evicted %0b",
                      " victim %02h total %0d"},
                     $realtime, got.page, got.frame, got.fault, got.evicted,
                     got.victim_page, got.fault_total);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("no transfer for %0d cycles", STALL_LIMIT);
      $display("nru_page_table_mmu_test: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int p = 0; p < npt_pkg::NUM_PAGES; p++) begin
      page_present[p] = 1'b0;
      page_ref[p] = 1'b0;
      page_mod[p] = 1'b0;
      page_frame[p] = '0;
    end
    frames_handed = 0;
    prev_page = '0;
    prev_valid = 1'b0;
    faults = '0;
    frame_limit_reg = FRAMES_AT_RESET;
    scan_start = npt_pkg::LFSR_W'(1);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_accesses();
    test_frame_limit();
    test_scan_seed();
    test_random_traffic();
    settle_block();
    $display("%0d accesses over %0d register settings, %0d evictions, %0d faults",
             accesses_sent, config_writes, evictions_predicted, faults);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && expected_translations.size() == 0) begin
      $display("nru_page_table_mmu_test: clean");
    end else begin
      $display("nru_page_table_mmu_test: errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/npt_pkg.sv
src/npt_ctrl.sv
src/npt_datapath.sv
src/nru_page_table_mmu.sv
test/nru_page_table_mmu_test.sv
